// ----- hdl/swm_pkg.sv -----
package swm_pkg;

  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = CFG_W'(1);

endpackage

// ----- hdl/swm_if.sv -----
interface swm_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           end_of_sequence;

  modport source (output valid, output sample, output end_of_sequence, input ready);
  modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;
  logic                           last_of_run;

  modport source (output valid, output window_max, output last_of_run, input ready);
  modport sink   (input valid, input window_max, input last_of_run, output ready);
endinterface

interface swm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [swm_pkg::CFG_W-1:0]        window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

// ----- hdl/sliding_window_maximum.sv -----
// Sliding window maximum over a stream of signed samples.
// in_ch  : sample plus end_of_sequence; one transaction per cycle when ready.
// out_ch : window_max plus last_of_run; zero or one transaction per input.
// cfg_ch : window_length write, always ready; write only while idle.
//   A length of 0 acts as 1, anything above WINDOW_MAX acts as WINDOW_MAX.
// Once window_length samples of a sequence have arrived, each input yields
// the maximum of its newest window_length samples. end_of_sequence marks
// the last sample; its result (if any) carries last_of_run and the history
// starts over. Shorter sequences yield nothing.
// Result path: input registered in the cells and pend_r, then in out_max_r.
// Throughput: 1 sample per cycle when ready, set by the cell chain: cell i
//   keeps the max of the newest i+1 samples via one compare with cell i-1.
// Reset: empty history, window_length = 1, no pending results.
// Stall: a held output plus one pending result are buffered; in_ch.ready
//   drops while both are occupied and out_ch.ready is low.
module sliding_window_maximum #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic   clk,
  input logic   rst_n,
  swm_in_if.sink    in_ch,
  swm_out_if.source out_ch,
  swm_cfg_if.sink   cfg_ch
);
  import swm_pkg::*;

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW    = $clog2(WINDOW_MAX + 1);
  localparam int EW    = (FW > CFG_W) ? FW : CFG_W;

  logic [CFG_W-1:0] window_length_r;
  logic [FW-1:0]    fill_r;
  logic [FW-1:0]    fill_inc;
  logic [EW-1:0]    k_eff;
  logic [IDX_W-1:0] sel_idx;
  logic             accept;
  logic             out_free;
  logic             have_res;
  logic             pend_r;
  logic             pend_last_r;
  logic             out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_max_r;
  logic             out_last_r;

  logic signed [SAMPLE_WIDTH-1:0] cell_max [WINDOW_MAX];
  logic        [SAMPLE_WIDTH-1:0] cell_tap [WINDOW_MAX];
  logic        [SAMPLE_WIDTH-1:0] tap_or;

  always_comb begin
    priority if (window_length_r == '0) begin
      k_eff = EW'(1);
    end else if (EW'(window_length_r) > EW'(WINDOW_MAX)) begin
      k_eff = EW'(WINDOW_MAX);
    end else begin
      k_eff = EW'(window_length_r);
    end
  end

  assign sel_idx  = IDX_W'(k_eff - EW'(1));
  assign fill_inc = (fill_r == FW'(WINDOW_MAX)) ? fill_r : fill_r + FW'(1);
  assign have_res = EW'(fill_inc) >= k_eff;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !pend_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .IDX_W       (IDX_W),
      .IDX         (i)
    ) u_cell (
      .clk       (clk),
      .en        (accept),
      .sample_i  (in_ch.sample),
      .prev_max_i((i == 0) ? in_ch.sample : cell_max[(i == 0) ? 0 : i - 1]),
      .sel_idx_i (sel_idx),
      .max_o     (cell_max[i]),
      .tap_o     (cell_tap[i])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_LENGTH_RST;
      fill_r          <= '0;
      pend_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        window_length_r <= cfg_ch.window_length;
      end
      if (accept) begin
        fill_r <= in_ch.end_of_sequence ? '0 : fill_inc;
        pend_r <= have_res;
      end else if (pend_r && out_free) begin
        pend_r <= 1'b0;
      end
      if (pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_last_r <= in_ch.end_of_sequence;
    end
    if (pend_r && out_free) begin
      out_max_r  <= SAMPLE_WIDTH'(tap_or);
      out_last_r <= pend_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.window_max  = out_max_r;
  assign out_ch.last_of_run = out_last_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both result slots are full");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_MAX))
    else $error("fill count above window capacity");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_sequence) |=> (fill_r == '0))
    else $error("history not cleared after end of sequence");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_ch.end_of_sequence && fill_r != FW'(WINDOW_MAX))
      |=> (fill_r == $past(fill_r) + FW'(1)))
    else $error("fill count did not advance");

  a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_free && !accept) |=> (!pend_r && out_valid_r))
    else $error("pending result not moved to output");

endmodule

// ----- hdl/swm_cell.sv -----
module swm_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int IDX_W        = 6,
  parameter int IDX          = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_max_i,
  input  logic        [IDX_W-1:0]        sel_idx_i,
  output logic signed [SAMPLE_WIDTH-1:0] max_o,
  output logic        [SAMPLE_WIDTH-1:0] tap_o
);

  // max_r holds the maximum of the newest IDX+1 samples
  logic signed [SAMPLE_WIDTH-1:0] max_r;
  logic signed [SAMPLE_WIDTH-1:0] max_nxt;

  assign max_nxt = (prev_max_i > sample_i) ? prev_max_i : sample_i;

  always_ff @(posedge clk) begin
    if (en) begin
      max_r <= max_nxt;
    end
  end

  assign max_o = max_r;
  assign tap_o = (sel_idx_i == IDX_W'(IDX)) ? max_r : '0;

endmodule
